[rtl/gwm_pkg.sv]
// Shared types, codes and byte helpers for the glob wildcard matcher.
package gwm_pkg;

	typedef enum logic [1:0] {
		FUNC_APPEND_PAT = 2'd0,
		FUNC_APPEND_TXT = 2'd1,
		FUNC_EVAL       = 2'd2,
		FUNC_CLEAR_PAT  = 2'd3
	} func_t;

	localparam logic [7:0] CH_ANY  = 8'h3F;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_UC_A = 8'h41;
	localparam logic [7:0] CH_UC_Z = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Control from the front end to the walker.
	typedef struct packed {
		logic start;
		logic ack;
	} gwm_ctrl_t;

	// Status from the walker back to the front end.
	typedef struct packed {
		logic busy;
		logic done;
		logic match;
	} gwm_stat_t;

	// Fold ASCII upper case to lower case; everything else passes exactly.
	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			r = c + CASE_OFS;
		end
		return r;
	endfunction

endpackage

[rtl/gwm_ram.sv]
// Simple dual-port byte store: one write port, one registered read port.
module gwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/gwm_walker.sv]
// Match walker: steps pattern and text indices through both stores, one step a cycle.
module gwm_walker #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT = 256,
	localparam int PW = $clog2(MAX_PATTERN + 1),
	localparam int TW = $clog2(MAX_TEXT + 1),
	localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
	localparam int TA = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gwm_pkg::gwm_ctrl_t ctrl,
	input  logic [PW-1:0]     plen,
	input  logic [TW-1:0]     tlen,
	output logic [PA-1:0]     pat_raddr,
	output logic [TA-1:0]     txt_raddr,
	input  logic [7:0]        pat_rdata,
	input  logic [7:0]        txt_rdata,
	output gwm_pkg::gwm_stat_t stat
);

	typedef enum logic [1:0] {
		W_IDLE,
		W_WALK,
		W_DONE
	} wstate_t;

	wstate_t       state_q;
	logic          match_q;
	logic [PW-1:0] pi_q, pi_n, star_q, star_n;
	logic [TW-1:0] ti_q, ti_n, resume_q, resume_n;
	logic          have_q, have_n;
	logic          p_ok, t_ok, hit, is_star, fin, fin_match;

	// Read data always belongs to (pi_q, ti_q): the address is the next index.
	assign pat_raddr = pi_n[PA-1:0];
	assign txt_raddr = ti_n[TA-1:0];

	always_comb begin
		pi_n = pi_q;
		ti_n = ti_q;
		star_n = star_q;
		resume_n = resume_q;
		have_n = have_q;
		fin = 1'b0;
		fin_match = 1'b0;
		p_ok = (pi_q < plen);
		t_ok = (ti_q < tlen);
		is_star = (pat_rdata == gwm_pkg::CH_STAR);
		hit = p_ok && (pat_rdata == gwm_pkg::CH_ANY ||
			gwm_pkg::fold_byte(pat_rdata) == gwm_pkg::fold_byte(txt_rdata));
		unique case (state_q)
			W_IDLE: begin
				if (ctrl.start) begin
					pi_n = '0;
					ti_n = '0;
					have_n = 1'b0;
				end
			end
			W_WALK: begin
				if (t_ok) begin
					if (hit) begin
						pi_n = pi_q + PW'(1);
						ti_n = ti_q + TW'(1);
					end else if (p_ok && is_star) begin
						star_n = pi_q;
						pi_n = pi_q + PW'(1);
						resume_n = ti_q;
						have_n = 1'b1;
					end else if (have_q) begin
						pi_n = star_q + PW'(1);
						resume_n = resume_q + TW'(1);
						ti_n = resume_q + TW'(1);
					end else begin
						fin = 1'b1;
					end
				end else if (p_ok && is_star) begin
					// skip trailing stars
					pi_n = pi_q + PW'(1);
				end else begin
					fin = 1'b1;
					fin_match = (pi_q == plen);
				end
			end
			W_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			match_q <= 1'b0;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (ctrl.start) begin
						state_q <= W_WALK;
					end
				end
				W_WALK: begin
					if (fin) begin
						state_q <= W_DONE;
						match_q <= fin_match;
					end
				end
				W_DONE: begin
					if (ctrl.ack) begin
						state_q <= W_IDLE;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pi_q <= pi_n;
		ti_q <= ti_n;
		star_q <= star_n;
		resume_q <= resume_n;
		have_q <= have_n;
	end

	assign stat.busy = (state_q != W_IDLE);
	assign stat.done = (state_q == W_DONE);
	assign stat.match = match_q;

endmodule

[rtl/glob_wildcard_matcher.sv]
// Top level of the glob wildcard matcher: command front end, two byte stores, walker.
//
// Input beats (s_axis_*) carry a command in tuser and a byte in tdata: append a
// pattern byte, append a text byte, evaluate, clear the pattern. Appends and
// pattern clear give no output beat and keep tready high, so a new beat can
// follow in the next cycle. An append to a full store is dropped and sets a
// sticky overflow flag.
// Evaluate launches the walker on its accept cycle; the walker then takes one
// step per cycle (a character match, a star entry, a backtrack to the last star,
// or a trailing star skip), paced by the registered store reads, then sees the
// end of the walk and loads the result into the output register once that
// register is free.
// Input tready is low from evaluate acceptance until the result is loaded.
// The result beat (m_axis_*) holds matched in tdata bit 0 and overflowed in tuser;
// matched is forced low when overflowed is set. Evaluate then clears the text
// and the flag; the pattern stays. While m_axis_tready is low a finished result
// waits in the output register and appends keep flowing; a second evaluate
// holds its result in the walker until the register frees up.
// Reset clears lengths, flag and control state; store contents stay unknown.
module glob_wildcard_matcher #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT = 256,
	localparam int PW = $clog2(MAX_PATTERN + 1),
	localparam int TW = $clog2(MAX_TEXT + 1),
	localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
	localparam int TA = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_byte
	input  logic [1:0] s_axis_tuser,  // [1:0] func
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [0] matched, [7:1] zero
	output logic [0:0] m_axis_tuser   // [0] overflowed
);

	gwm_pkg::gwm_ctrl_t ctrl;
	gwm_pkg::gwm_stat_t stat;
	gwm_pkg::func_t     func;

	logic          busy_q;
	logic [PW-1:0] plen_q;
	logic [TW-1:0] tlen_q;
	logic          ovf_q;
	logic          m_valid_q, m_match_q, m_ovf_q;

	logic          in_beat;
	logic          pat_we, txt_we;
	logic          pat_room, txt_room;
	logic [PA-1:0] pat_raddr;
	logic [TA-1:0] txt_raddr;
	logic [7:0]    pat_rdata, txt_rdata;

	assign func = gwm_pkg::func_t'(s_axis_tuser);
	assign s_axis_tready = !busy_q;
	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign pat_room = (plen_q < PW'(MAX_PATTERN));
	assign txt_room = (tlen_q < TW'(MAX_TEXT));
	assign pat_we = in_beat && func == gwm_pkg::FUNC_APPEND_PAT && pat_room;
	assign txt_we = in_beat && func == gwm_pkg::FUNC_APPEND_TXT && txt_room;

	// Launch the walker on evaluate; retire it once the output register is free.
	assign ctrl.start = in_beat && func == gwm_pkg::FUNC_EVAL;
	assign ctrl.ack = stat.done && (!m_valid_q || m_axis_tready);

	gwm_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(plen_q[PA-1:0]),
		.wdata(s_axis_tdata),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	gwm_ram #(
		.WIDTH(8),
		.DEPTH(MAX_TEXT)
	) u_txt_ram (
		.clk  (clk),
		.we   (txt_we),
		.waddr(tlen_q[TA-1:0]),
		.wdata(s_axis_tdata),
		.raddr(txt_raddr),
		.rdata(txt_rdata)
	);

	gwm_walker #(
		.MAX_PATTERN(MAX_PATTERN),
		.MAX_TEXT(MAX_TEXT)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.plen     (plen_q),
		.tlen     (tlen_q),
		.pat_raddr(pat_raddr),
		.txt_raddr(txt_raddr),
		.pat_rdata(pat_rdata),
		.txt_rdata(txt_rdata),
		.stat     (stat)
	);

	// Command front end: lengths, overflow flag, busy interlock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			plen_q <= '0;
			tlen_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (in_beat) begin
				case (func)
					gwm_pkg::FUNC_APPEND_PAT: begin
						if (pat_room) begin
							plen_q <= plen_q + PW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					gwm_pkg::FUNC_APPEND_TXT: begin
						if (txt_room) begin
							tlen_q <= tlen_q + TW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					gwm_pkg::FUNC_EVAL: begin
						busy_q <= 1'b1;
					end
					default: begin
						plen_q <= '0;
					end
				endcase
			end
			if (ctrl.ack) begin
				// drop the text and the flag, keep the pattern
				busy_q <= 1'b0;
				tlen_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Output register: load on walker retire, drop on downstream beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.ack) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ack) begin
			m_match_q <= stat.match && !ovf_q;
			m_ovf_q <= ovf_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {7'b0, m_match_q};
	assign m_axis_tuser = m_ovf_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= PW'(MAX_PATTERN) && tlen_q <= TW'(MAX_TEXT))
		else $error("store length beyond capacity");

	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> !s_axis_tready && stat.busy)
		else $error("evaluate did not lock the input");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> busy_q)
		else $error("walker finished without a pending evaluate");

	a_retire_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ack |=> tlen_q == '0 && !ovf_q && m_axis_tvalid)
		else $error("evaluate retire did not clear text or load result");

	a_ovf_forces: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[0])
		else $error("match reported together with overflow");

endmodule
